### sv/closest_point_on_triangle_defines.svh
// ----------------------------------------------------------------------------
// Closest point on triangle: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH

// plain property check
`define CPOT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define CPOT_ASSERT_IMP(name, ante, cons, msg) \
  `CPOT_ASSERT(name, (ante) |-> (cons), msg)

`endif

### sv/cpot_pkg.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: package
// Widths, pipeline stage numbers, region codes and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package cpot_pkg;

  localparam int CW    = 24;          // coordinate width
  localparam int WFB   = 16;          // weight fraction bits
  localparam int WW    = WFB + 1;     // weight width
  localparam int EW    = CW + 1;      // edge / offset vector width
  localparam int PW    = 2 * EW;      // single product
  localparam int DOTW  = PW + 2;      // dot product
  localparam int HW    = DOTW / 2;    // half of a dot product
  localparam int XW    = 2 * DOTW;    // full cross product
  localparam int VW    = XW + 1;      // cross difference
  localparam int DIVW  = VW + 3;      // divider operands
  localparam int MW    = EW + WW + 1; // edge times weight
  localparam int SW    = MW + 1;
  localparam int PTW   = SW + 1;
  localparam int DISTW = 2 * CW + 4;
  localparam int ITER  = WFB;

  localparam int ST_PROD  = 1;
  localparam int ST_DOT   = 2;
  localparam int ST_PART  = 3;
  localparam int ST_WIDE  = 4;
  localparam int ST_CROSS = 5;
  localparam int ST_SEL   = 6;
  localparam int ST_ABS   = 7;
  localparam int ST_CMP   = 8;
  localparam int ST_WGT   = ST_CMP + ITER + 1;
  localparam int ST_MUL   = ST_WGT + 1;
  localparam int ST_PT    = ST_MUL + 1;
  localparam int ST_SQ    = ST_PT + 1;
  localparam int ST_OUT   = ST_SQ + 1;
  localparam int NST      = ST_OUT + 1;

  // operand pairs of the six cross-term products
  localparam int XSEL [6] = '{0, 2, 4, 0, 2, 4};
  localparam int YSEL [6] = '{3, 1, 1, 5, 5, 3};

  localparam logic [WW-1:0] ONE = {1'b1, {WFB{1'b0}}};

  typedef enum logic [2:0] {
    R_VTX_A   = 3'd0,
    R_VTX_B   = 3'd1,
    R_EDGE_AB = 3'd2,
    R_VTX_C   = 3'd3,
    R_EDGE_AC = 3'd4,
    R_EDGE_BC = 3'd5,
    R_FACE    = 3'd6
  } region_e;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [EW-1:0] vec_t;

  typedef struct packed {
    crd_t [2:0] a;
    crd_t [2:0] b;
    crd_t [2:0] c;
    crd_t [2:0] p;
    vec_t [2:0] ab;
    vec_t [2:0] ac;
    vec_t [2:0] bc;
  } geo_t;

  typedef struct packed {
    region_e        region;
    logic           degen;
    logic [WW-1:0]  wa;
    logic [WW-1:0]  wb;
    logic [WW-1:0]  wc;
  } info_t;

  typedef struct packed {
    logic [DIVW-1:0] r;
    logic [DIVW-1:0] b;
    logic [ITER-1:0] q;
    logic            zero;
    logic            one;
  } div_t;

endpackage

`default_nettype wire

### sv/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// Closest point on triangle
// Voronoi region classification, barycentric weights, closest point and
// squared distance for one triangle and one query point per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request: vertices a, b,
//   c and the query point, signed Q15.8. Output channel out_valid_o /
//   out_stall_i returns one result per request, in request order.
//   A request is taken at a rising edge with valid high and stall low.
//   Throughput is one request per cycle while in_stall_o is low. A request
//   passes the 30-stage pipeline from the accepting edge to out_valid_o: dot
//   products, split 52x52 cross products, region select, compare, a 16-stage
//   one-bit-per-stage restoring divider pair, interpolation and distance.
//   Reset clears all stage valid bits; no request is in flight afterwards.
//   When the receiver stalls, the result holds; stages behind it keep
//   filling their empty slots and in_stall_o rises only once every stage
//   holds a request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "closest_point_on_triangle_defines.svh"

module closest_point_on_triangle (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpot_pkg::CW-1:0]      a_x_i,
  input  logic signed [cpot_pkg::CW-1:0]      a_y_i,
  input  logic signed [cpot_pkg::CW-1:0]      a_z_i,
  input  logic signed [cpot_pkg::CW-1:0]      b_x_i,
  input  logic signed [cpot_pkg::CW-1:0]      b_y_i,
  input  logic signed [cpot_pkg::CW-1:0]      b_z_i,
  input  logic signed [cpot_pkg::CW-1:0]      c_x_i,
  input  logic signed [cpot_pkg::CW-1:0]      c_y_i,
  input  logic signed [cpot_pkg::CW-1:0]      c_z_i,
  input  logic signed [cpot_pkg::CW-1:0]      query_x_i,
  input  logic signed [cpot_pkg::CW-1:0]      query_y_i,
  input  logic signed [cpot_pkg::CW-1:0]      query_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpot_pkg::CW-1:0]      closest_x_o,
  output logic signed [cpot_pkg::CW-1:0]      closest_y_o,
  output logic signed [cpot_pkg::CW-1:0]      closest_z_o,
  output logic        [cpot_pkg::WW-1:0]      weight_a_o,
  output logic        [cpot_pkg::WW-1:0]      weight_b_o,
  output logic        [cpot_pkg::WW-1:0]      weight_c_o,
  output logic        [cpot_pkg::DISTW-1:0]   dist_squared_o,
  output logic        [2:0]                   region_o,
  output logic                                degenerate_o
);

  import cpot_pkg::*;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  geo_t  geo_d;
  geo_t  geo_q  [NST];
  info_t info_q [NST];
  info_t sel_info_d, wgt_info_d;

  vec_t ap_d [3], bp_d [3], cp_d [3];
  vec_t ap_q [3], bp_q [3], cp_q [3];

  logic signed [PW-1:0]   prod_d [18], prod_q [18];
  logic signed [DOTW-1:0] dot_d [6], dot_q [6], dot3_q [6], dot4_q [6], dot5_q [6];

  logic signed [2*HW-1:0] hh_d [6], hh_q [6];
  logic signed [2*HW:0]   hl_d [6], hl_q [6], lh_d [6], lh_q [6];
  logic        [2*HW-1:0] ll_d [6], ll_q [6];
  logic signed [XW-1:0]   wide_d [6], wide_q [6];
  logic signed [VW-1:0]   va_d, vb_d, vc_d, va_q, vb_q, vc_q;

  logic signed [DIVW-1:0] num_d [2], den_d [2], num_q [2], den_q [2];
  div_t abs_d [2], abs_q [2];
  div_t dv_d [2][ITER+1];
  div_t dv_q [2][ITER+1];

  logic [WW-1:0] s_d, t_d, s_q, t_q;
  vec_t e1_d [3], e2_d [3], e1_q [3], e2_q [3];
  crd_t base_d [3], base_q [3], base26_q [3];
  logic signed [MW-1:0] m1_d [3], m2_d [3], m1_q [3], m2_q [3];
  crd_t pt_d [3], pt_q [3], pt28_q [3], pt29_q [3];
  logic [PW-1:0] sq_d [3], sq_q [3];
  logic [DISTW-1:0] dist_d, dist_q;

  // enable chain: a stage loads when empty or when the next one moves
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  // stage 0: capture and edge vectors
  always_comb begin
    geo_d.a[0] = a_x_i;     geo_d.a[1] = a_y_i;     geo_d.a[2] = a_z_i;
    geo_d.b[0] = b_x_i;     geo_d.b[1] = b_y_i;     geo_d.b[2] = b_z_i;
    geo_d.c[0] = c_x_i;     geo_d.c[1] = c_y_i;     geo_d.c[2] = c_z_i;
    geo_d.p[0] = query_x_i; geo_d.p[1] = query_y_i; geo_d.p[2] = query_z_i;
    for (int k = 0; k < 3; k++) begin
      geo_d.ab[k] = EW'(geo_d.b[k]) - EW'(geo_d.a[k]);
      geo_d.ac[k] = EW'(geo_d.c[k]) - EW'(geo_d.a[k]);
      geo_d.bc[k] = EW'(geo_d.c[k]) - EW'(geo_d.b[k]);
      ap_d[k]     = EW'(geo_d.p[k]) - EW'(geo_d.a[k]);
      bp_d[k]     = EW'(geo_d.p[k]) - EW'(geo_d.b[k]);
      cp_d[k]     = EW'(geo_d.p[k]) - EW'(geo_d.c[k]);
    end
  end

  // stage 1: component products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k]      = geo_q[0].ab[k] * ap_q[k];
      prod_d[3 + k]  = geo_q[0].ac[k] * ap_q[k];
      prod_d[6 + k]  = geo_q[0].ab[k] * bp_q[k];
      prod_d[9 + k]  = geo_q[0].ac[k] * bp_q[k];
      prod_d[12 + k] = geo_q[0].ab[k] * cp_q[k];
      prod_d[15 + k] = geo_q[0].ac[k] * cp_q[k];
    end
  end

  // stage 2: dot products d1..d6
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dot_d[j] = DOTW'(prod_q[3*j]) + DOTW'(prod_q[3*j+1]) + DOTW'(prod_q[3*j+2]);
    end
  end

  // stage 3: partial products of the cross terms
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hh_d[i] = $signed(dot_q[XSEL[i]][DOTW-1:HW]) * $signed(dot_q[YSEL[i]][DOTW-1:HW]);
      hl_d[i] = $signed(dot_q[XSEL[i]][DOTW-1:HW]) * $signed({1'b0, dot_q[YSEL[i]][HW-1:0]});
      lh_d[i] = $signed({1'b0, dot_q[XSEL[i]][HW-1:0]}) * $signed(dot_q[YSEL[i]][DOTW-1:HW]);
      ll_d[i] = dot_q[XSEL[i]][HW-1:0] * dot_q[YSEL[i]][HW-1:0];
    end
  end

  // stage 4: recombine
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      wide_d[i] = (XW'(hh_q[i]) <<< (2 * HW)) + ((XW'(hl_q[i]) + XW'(lh_q[i])) <<< HW)
                + XW'(ll_q[i]);
    end
  end

  // stage 5: cross terms
  always_comb begin
    vc_d = VW'(wide_q[0]) - VW'(wide_q[1]);
    vb_d = VW'(wide_q[2]) - VW'(wide_q[3]);
    va_d = VW'(wide_q[4]) - VW'(wide_q[5]);
  end

  // stage 6: region and divider operands
  always_comb begin
    logic signed [DOTW:0]   d43, d56, d13, d26;
    logic signed [DIVW-1:0] den6;
    logic                   z1, z2, z3, z4, z5, z6;
    logic                   n1, n2, n3, n4, n5, n6;
    region_e                rg;
    z1 = (dot5_q[0] == '0); n1 = dot5_q[0][DOTW-1];
    z2 = (dot5_q[1] == '0); n2 = dot5_q[1][DOTW-1];
    z3 = (dot5_q[2] == '0); n3 = dot5_q[2][DOTW-1];
    z4 = (dot5_q[3] == '0); n4 = dot5_q[3][DOTW-1];
    z5 = (dot5_q[4] == '0); n5 = dot5_q[4][DOTW-1];
    z6 = (dot5_q[5] == '0); n6 = dot5_q[5][DOTW-1];
    d43  = (DOTW+1)'(dot5_q[3]) - (DOTW+1)'(dot5_q[2]);
    d56  = (DOTW+1)'(dot5_q[4]) - (DOTW+1)'(dot5_q[5]);
    d13  = (DOTW+1)'(dot5_q[0]) - (DOTW+1)'(dot5_q[2]);
    d26  = (DOTW+1)'(dot5_q[1]) - (DOTW+1)'(dot5_q[5]);
    den6 = DIVW'(va_q) + DIVW'(vb_q) + DIVW'(vc_q);

    if ((n1 || z1) && (n2 || z2)) begin
      rg = R_VTX_A;
    end else if (!n3 && (d43[DOTW] || d43 == '0)) begin
      rg = R_VTX_B;
    end else if ((vc_q[VW-1] || vc_q == '0) && !n1 && (n3 || z3)) begin
      rg = R_EDGE_AB;
    end else if (!n6 && (d56[DOTW] || d56 == '0)) begin
      rg = R_VTX_C;
    end else if ((vb_q[VW-1] || vb_q == '0) && !n2 && (n6 || z6)) begin
      rg = R_EDGE_AC;
    end else if ((va_q[VW-1] || va_q == '0) && !d43[DOTW] && !d56[DOTW]) begin
      rg = R_EDGE_BC;
    end else begin
      rg = R_FACE;
    end

    num_d[0] = '0; den_d[0] = '0;
    num_d[1] = '0; den_d[1] = '0;
    case (rg)
      R_EDGE_AB: begin
        num_d[0] = DIVW'(dot5_q[0]); den_d[0] = DIVW'(d13);
      end
      R_EDGE_AC: begin
        num_d[0] = DIVW'(dot5_q[1]); den_d[0] = DIVW'(d26);
      end
      R_EDGE_BC: begin
        num_d[0] = DIVW'(d43);       den_d[0] = DIVW'(d43) + DIVW'(d56);
      end
      R_FACE: begin
        num_d[0] = DIVW'(vb_q);      den_d[0] = den6;
        num_d[1] = DIVW'(vc_q);      den_d[1] = den6;
      end
      default: begin
      end
    endcase

    sel_info_d        = '0;
    sel_info_d.region = rg;
    sel_info_d.degen  = (rg == R_FACE) && (den6 == '0);
  end

  // stage 7: signs and magnitudes
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      abs_d[j].r    = num_q[j][DIVW-1] ? DIVW'(-num_q[j]) : DIVW'(num_q[j]);
      abs_d[j].b    = den_q[j][DIVW-1] ? DIVW'(-den_q[j]) : DIVW'(den_q[j]);
      abs_d[j].q    = '0;
      abs_d[j].zero = (num_q[j] == '0) || (den_q[j] == '0)
                   || (num_q[j][DIVW-1] != den_q[j][DIVW-1]);
      abs_d[j].one  = 1'b0;
    end
  end

  // stage 8 and divider iterations
  always_comb begin
    logic [DIVW-1:0] r2;
    for (int j = 0; j < 2; j++) begin
      dv_d[j][0]     = abs_q[j];
      dv_d[j][0].one = (abs_q[j].r >= abs_q[j].b);
      for (int i = 1; i <= ITER; i++) begin
        dv_d[j][i] = dv_q[j][i-1];
        r2 = {dv_q[j][i-1].r[DIVW-2:0], 1'b0};
        if (r2 >= dv_q[j][i-1].b) begin
          dv_d[j][i].r = r2 - dv_q[j][i-1].b;
          dv_d[j][i].q = {dv_q[j][i-1].q[ITER-2:0], 1'b1};
        end else begin
          dv_d[j][i].r = r2;
          dv_d[j][i].q = {dv_q[j][i-1].q[ITER-2:0], 1'b0};
        end
      end
    end
  end

  // weights and interpolation operands
  always_comb begin
    logic [WW-1:0] qv [2];
    logic [WW:0]   wsum;
    geo_t          g;
    g = geo_q[ST_WGT-1];
    for (int j = 0; j < 2; j++) begin
      qv[j] = dv_q[j][ITER].zero ? '0 :
              dv_q[j][ITER].one  ? ONE : {1'b0, dv_q[j][ITER].q};
    end
    wsum = {1'b0, ONE} - {1'b0, qv[0]} - {1'b0, qv[1]};
    s_d  = qv[0];
    t_d  = qv[1];
    for (int k = 0; k < 3; k++) begin
      e1_d[k]   = g.ab[k];
      e2_d[k]   = g.ac[k];
      base_d[k] = g.a[k];
    end
    wgt_info_d    = info_q[ST_WGT-1];
    wgt_info_d.wa = ONE;
    wgt_info_d.wb = '0;
    wgt_info_d.wc = '0;
    case (info_q[ST_WGT-1].region)
      R_VTX_B: begin
        for (int k = 0; k < 3; k++) base_d[k] = g.b[k];
        wgt_info_d.wa = '0; wgt_info_d.wb = ONE;
      end
      R_EDGE_AB: begin
        wgt_info_d.wa = ONE - qv[0]; wgt_info_d.wb = qv[0];
      end
      R_VTX_C: begin
        for (int k = 0; k < 3; k++) base_d[k] = g.c[k];
        wgt_info_d.wa = '0; wgt_info_d.wc = ONE;
      end
      R_EDGE_AC: begin
        for (int k = 0; k < 3; k++) e1_d[k] = g.ac[k];
        wgt_info_d.wa = ONE - qv[0]; wgt_info_d.wc = qv[0];
      end
      R_EDGE_BC: begin
        for (int k = 0; k < 3; k++) begin
          e1_d[k]   = g.bc[k];
          base_d[k] = g.b[k];
        end
        wgt_info_d.wa = '0; wgt_info_d.wb = ONE - qv[0]; wgt_info_d.wc = qv[0];
      end
      R_FACE: begin
        wgt_info_d.wa = wsum[WW] ? '0 : wsum[WW-1:0];
        wgt_info_d.wb = qv[0];
        wgt_info_d.wc = qv[1];
      end
      default: begin
      end
    endcase
  end

  // edge times weight
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1_d[k] = e1_q[k] * $signed({1'b0, s_q});
      m2_d[k] = e2_q[k] * $signed({1'b0, t_q});
    end
  end

  // floor, offset and saturate
  always_comb begin
    logic signed [SW-1:0]  sm;
    logic signed [PTW-1:0] x;
    for (int k = 0; k < 3; k++) begin
      sm = SW'(m1_q[k]) + SW'(m2_q[k]);
      x  = PTW'(base26_q[k]) + PTW'(sm >>> WFB);
      if (x[PTW-1:CW-1] == '0 || x[PTW-1:CW-1] == '1) begin
        pt_d[k] = x[CW-1:0];
      end else begin
        pt_d[k] = x[PTW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  // squared offsets and distance
  always_comb begin
    logic signed [EW-1:0] df;
    for (int k = 0; k < 3; k++) begin
      df      = EW'(pt_q[k]) - EW'(geo_q[ST_SQ-1].p[k]);
      sq_d[k] = PW'(df * df);
    end
    dist_d = DISTW'(sq_q[0]) + DISTW'(sq_q[1]) + DISTW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      geo_q[0] <= geo_d;
      ap_q     <= ap_d;
      bp_q     <= bp_d;
      cp_q     <= cp_d;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) geo_q[k] <= geo_q[k-1];
    end
    // the weight stage loads its own info below
    for (int k = ST_SEL + 1; k < NST; k++) begin
      if (en[k] && k != ST_WGT) info_q[k] <= info_q[k-1];
    end
    if (en[ST_PROD]) prod_q <= prod_d;
    if (en[ST_DOT])  dot_q  <= dot_d;
    if (en[ST_PART]) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      dot3_q <= dot_q;
    end
    if (en[ST_WIDE]) begin
      wide_q <= wide_d;
      dot4_q <= dot3_q;
    end
    if (en[ST_CROSS]) begin
      va_q   <= va_d;
      vb_q   <= vb_d;
      vc_q   <= vc_d;
      dot5_q <= dot4_q;
    end
    if (en[ST_SEL]) begin
      info_q[ST_SEL] <= sel_info_d;
      num_q          <= num_d;
      den_q          <= den_d;
    end
    if (en[ST_ABS]) abs_q <= abs_d;
    for (int i = 0; i <= ITER; i++) begin
      if (en[ST_CMP+i]) begin
        dv_q[0][i] <= dv_d[0][i];
        dv_q[1][i] <= dv_d[1][i];
      end
    end
    if (en[ST_WGT]) begin
      info_q[ST_WGT] <= wgt_info_d;
      s_q            <= s_d;
      t_q            <= t_d;
      e1_q           <= e1_d;
      e2_q           <= e2_d;
      base_q         <= base_d;
    end
    if (en[ST_MUL]) begin
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      base26_q <= base_q;
    end
    if (en[ST_PT]) pt_q <= pt_d;
    if (en[ST_SQ]) begin
      sq_q   <= sq_d;
      pt28_q <= pt_q;
    end
    if (en[ST_OUT]) begin
      dist_q <= dist_d;
      pt29_q <= pt28_q;
    end
  end

  assign out_valid_o    = vld_q[ST_OUT];
  assign closest_x_o    = pt29_q[0];
  assign closest_y_o    = pt29_q[1];
  assign closest_z_o    = pt29_q[2];
  assign weight_a_o     = info_q[ST_OUT].wa;
  assign weight_b_o     = info_q[ST_OUT].wb;
  assign weight_c_o     = info_q[ST_OUT].wc;
  assign dist_squared_o = dist_q;
  assign region_o       = info_q[ST_OUT].region;
  assign degenerate_o   = info_q[ST_OUT].degen;

  `CPOT_ASSERT_IMP(a_wsum, out_valid_o && (region_o != R_FACE), (19'(weight_a_o) + 19'(weight_b_o) + 19'(weight_c_o)) == 19'(ONE), "weights off the face do not sum to one")
  `CPOT_ASSERT_IMP(a_degen, out_valid_o && degenerate_o, (region_o == R_FACE) && (weight_a_o == ONE) && (weight_b_o == '0), "degenerate result is not vertex a")
  `CPOT_ASSERT_IMP(a_full, in_stall_o, (&vld_q) && out_stall_i, "input stalled with an empty stage")

endmodule

`default_nettype wire
